### rtl/core/assert_macros.svh
// Assertion helpers shared by the span filler RTL.
// Each macro expands to a labelled concurrent assertion in simulation and to
// nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property holds at every rising clock edge outside reset.
`define CPSF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Condition never holds at a rising clock edge outside reset.
`define CPSF_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define CPSF_ASSERT(lbl, clk, rstn, prop, msg)
`define CPSF_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

### rtl/core/cpsf_pkg.sv
package cpsf_pkg;

  // Coordinate and table entry widths.
  localparam int XW = 9;
  localparam int LW = 10;
  localparam logic [LW-1:0] EMPTY_LEFT = 10'd1023;

  // Defaults for the top level parameters.
  localparam int ROWS_DEF      = 512;
  localparam int FRAC_BITS_DEF = 16;

  // Stream word layout.
  localparam int CMD_W       = 2;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (XW + LW + XW);
  localparam int IN_PAD_W    = IN_TDATA_W - 5 * XW;

  // Command codes carried on the input tuser.
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_EDGE  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_WALK,
    ST_DRAIN,
    ST_READ
  } state_e;

  // Request and status between the sequencer and the slope divider.
  typedef struct packed {
    logic          start;
    logic [XW-1:0] dx;
    logic [XW-1:0] dy;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### rtl/core/cpsf_ram.sv
module cpsf_ram #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port; read data holds when idle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/cpsf_div.sv
`include "assert_macros.svh"

module cpsf_div import cpsf_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  div_req_t                req_i,
  output div_stat_t               stat_o,
  output logic [XW+FRAC_BITS-1:0] quot_o
);

  localparam int QW = XW + FRAC_BITS;
  localparam int CW = $clog2(QW + 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [XW-1:0] rem_q, rem_d, dy_q;
  logic [QW-1:0] quo_q;
  logic [XW:0]   rem_sh, diff;
  logic          ge;

  // One restoring step: bring in the next dividend bit and try to subtract.
  always_comb begin
    rem_sh = {rem_q, quo_q[QW-1]};
    diff   = rem_sh - {1'b0, dy_q};
    ge     = rem_sh >= {1'b0, dy_q};
    rem_d  = ge ? diff[XW-1:0] : rem_sh[XW-1:0];
  end

  // Control: the unit runs for one cycle per quotient bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(QW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend shifts out at the top while quotient bits enter below.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= {req_i.dx, {FRAC_BITS{1'b0}}};
      rem_q <= '0;
      dy_q  <= req_i.dy;
    end else if (busy_q) begin
      quo_q <= {quo_q[QW-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quo_q;

  `CPSF_NEVER(a_start_while_busy, clk_i, rst_ni, req_i.start && busy_q, "divider restarted while busy")
  `CPSF_ASSERT(a_done_after_busy, clk_i, rst_ni, $fell(busy_q) |-> done_q, "busy ended without done")
  `CPSF_NEVER(a_zero_divisor, clk_i, rst_ni, req_i.start && (req_i.dy == '0), "divide by zero requested")

endmodule

### rtl/core/convex_polygon_span_fill_top.sv
// Scan-line span filler for convex polygons.
// Input words arrive on the s_axis channel; tuser carries the command (clear
// tables, walk edge, read row span) and tdata the endpoints and query row.
// Only a read command produces an output word on the m_axis channel: the row,
// its leftmost and rightmost x in tdata and the valid flag in tuser.
// Steps per command, set by the table memory port and the slope divider:
//   clear : one table row written per cycle.
//   edge  : when the edge is not horizontal, the divider makes one quotient
//           bit per cycle and then the slope is loaded; the rows are walked,
//           one read-modify-write per cycle, and a drain state follows.
//   read  : the table read is registered at acceptance; the word enters the
//           output register once it is empty or its word is being taken.
// After reset the block sweeps all ROWS table rows before it raises
// s_axis_tready_o for the first time.
// The output register lets clear and edge commands go on while a word still
// waits; a read then stalls until the receiver takes the pending word, and
// no new word is accepted meanwhile.
`include "assert_macros.svh"

module convex_polygon_span_fill_top import cpsf_pkg::*; #(
  parameter int ROWS      = ROWS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // start_x, start_y, end_x, end_y, query_row, zero padding
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // command
  input  logic [CMD_W-1:0]       s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // span_row, span_left, span_right, zero padding
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // span_valid
  output logic [0:0]             m_axis_tuser_o
);

  localparam int AW  = $clog2(ROWS);
  localparam int XFW = XW + FRAC_BITS;
  localparam int EW  = LW + XW;

  state_e state_q, state_d;

  // Input word fields.
  logic [XW-1:0] in_sx, in_sy, in_ex, in_ey, in_qr;
  logic [XW-1:0] in_lo_x, in_lo_y, in_hi_x, in_hi_y, in_dx, in_dy;
  logic          in_left;

  // Edge walk registers.
  logic [XW-1:0]  y_q, hi_y_q;
  logic [XFW-1:0] xf_q, xf_next, step_q;
  logic           left_q;
  logic           y_in_range;

  // Read-modify-write stage.
  logic          p_valid_q;
  logic [AW-1:0] p_addr_q;
  logic [XW-1:0] p_x_q;
  logic [LW-1:0] old_left, new_left;
  logic [XW-1:0] old_right, new_right;

  // Clear sweep.
  logic [AW-1:0] clr_cnt_q;

  // Read path and output register.
  logic          rd_oob_q;
  logic [XW-1:0] rd_row_q;
  logic          out_valid_q;
  logic [XW-1:0] out_row_q, out_right_q;
  logic [LW-1:0] out_left_q;
  logic          out_span_q;
  logic [LW-1:0] rd_left;
  logic [XW-1:0] rd_right;

  // Sequencer outputs.
  logic          accept, walk_issue, load_out, ram_re, ram_we;
  logic [AW-1:0] ram_raddr, ram_waddr;
  logic [EW-1:0] ram_wdata, ram_rdata;
  div_req_t      div_req;
  div_stat_t     div_stat;
  logic [XFW-1:0] div_quot;

  // Unpack the input word and order the endpoints; equal y takes end as lower.
  always_comb begin
    in_sx   = s_axis_tdata_i[0*XW +: XW];
    in_sy   = s_axis_tdata_i[1*XW +: XW];
    in_ex   = s_axis_tdata_i[2*XW +: XW];
    in_ey   = s_axis_tdata_i[3*XW +: XW];
    in_qr   = s_axis_tdata_i[4*XW +: XW];
    if (in_sy < in_ey) begin
      in_lo_x = in_sx;
      in_lo_y = in_sy;
      in_hi_x = in_ex;
      in_hi_y = in_ey;
    end else begin
      in_lo_x = in_ex;
      in_lo_y = in_ey;
      in_hi_x = in_sx;
      in_hi_y = in_sy;
    end
    in_left = in_hi_x < in_lo_x;
    in_dx   = in_left ? (in_lo_x - in_hi_x) : (in_hi_x - in_lo_x);
    in_dy   = in_hi_y - in_lo_y;
  end

  assign accept     = s_axis_tvalid_i && s_axis_tready_o;
  assign y_in_range = 32'(y_q) < ROWS;

  // Next state and sequencer controls.
  always_comb begin
    state_d         = state_q;
    s_axis_tready_o = 1'b0;
    walk_issue      = 1'b0;
    load_out        = 1'b0;
    ram_re          = 1'b0;
    ram_raddr       = AW'(in_qr);
    div_req.start   = 1'b0;
    div_req.dx      = in_dx;
    div_req.dy      = in_dy;
    case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == AW'(ROWS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          case (s_axis_tuser_i)
            CMD_CLEAR: state_d = ST_CLEAR;
            CMD_EDGE: begin
              if (in_dy != '0) begin
                div_req.start = 1'b1;
                state_d       = ST_DIV;
              end else begin
                state_d = ST_WALK;
              end
            end
            CMD_READ: begin
              ram_re  = 32'(in_qr) < ROWS;
              state_d = ST_READ;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        walk_issue = 1'b1;
        ram_re     = y_in_range;
        ram_raddr  = AW'(y_q);
        if (y_q == hi_y_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_IDLE;
      ST_READ: begin
        if (!out_valid_q || m_axis_tready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      p_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= (state_q == ST_CLEAR && state_d == ST_CLEAR) ? clr_cnt_q + 1'b1 : '0;
      p_valid_q <= walk_issue && y_in_range;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Next x: step right, or step left and stop at zero.
  always_comb begin
    if (left_q) begin
      xf_next = (xf_q >= step_q) ? (xf_q - step_q) : '0;
    end else begin
      xf_next = xf_q + step_q;
    end
  end

  // Edge walk, read and read-modify-write payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      y_q      <= in_lo_y;
      hi_y_q   <= in_hi_y;
      xf_q     <= {in_lo_x, {FRAC_BITS{1'b0}}};
      left_q   <= in_left;
      step_q   <= '0;
      rd_row_q <= in_qr;
      rd_oob_q <= !(32'(in_qr) < ROWS);
    end else if (div_stat.done) begin
      step_q <= div_quot;
    end else if (walk_issue) begin
      y_q  <= y_q + 1'b1;
      xf_q <= xf_next;
    end
    p_addr_q <= AW'(y_q);
    p_x_q    <= xf_q[XFW-1:FRAC_BITS];
  end

  // Widen the stored span with the floored x of the walked row.
  always_comb begin
    old_left  = ram_rdata[LW-1:0];
    old_right = ram_rdata[EW-1:LW];
    new_left  = ({1'b0, p_x_q} < old_left) ? {1'b0, p_x_q} : old_left;
    new_right = (p_x_q > old_right) ? p_x_q : old_right;
  end

  // Write port: clear sweep or span update.
  always_comb begin
    ram_we = (state_q == ST_CLEAR) || p_valid_q;
    if (state_q == ST_CLEAR) begin
      ram_waddr = clr_cnt_q;
      ram_wdata = {{XW{1'b0}}, EMPTY_LEFT};
    end else begin
      ram_waddr = p_addr_q;
      ram_wdata = {new_right, new_left};
    end
  end

  // Rows outside the table read as empty.
  assign rd_left  = rd_oob_q ? EMPTY_LEFT : ram_rdata[LW-1:0];
  assign rd_right = rd_oob_q ? '0 : ram_rdata[EW-1:LW];

  // Output word register.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_row_q   <= rd_row_q;
      out_left_q  <= rd_left;
      out_right_q <= rd_right;
      out_span_q  <= rd_left <= {1'b0, rd_right};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{OUT_PAD_W{1'b0}}, out_right_q, out_left_q, out_row_q};
  assign m_axis_tuser_o  = out_span_q;

  cpsf_ram #(
    .WIDTH (EW),
    .DEPTH (ROWS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  cpsf_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .stat_o (div_stat),
    .quot_o (div_quot)
  );

  `CPSF_NEVER(a_update_outside_walk, clk_i, rst_ni, p_valid_q && (state_q != ST_WALK) && (state_q != ST_DRAIN), "span update outside an edge walk")
  `CPSF_ASSERT(a_walk_rows_differ, clk_i, rst_ni, p_valid_q && $past(p_valid_q) |-> p_addr_q != $past(p_addr_q), "back-to-back updates of one row")
  `CPSF_ASSERT(a_read_from_idle, clk_i, rst_ni, (state_q == ST_READ) |-> ($past(state_q) == ST_IDLE) || ($past(state_q) == ST_READ), "read state entered outside idle")
  `CPSF_NEVER(a_accept_with_update, clk_i, rst_ni, s_axis_tready_o && p_valid_q, "word accepted while an update is pending")

endmodule

### bench/tb_convex_polygon_span_fill_top.sv
module tb_convex_polygon_span_fill_top;
  import cpsf_pkg::*;

  localparam int NUM_ROWS = ROWS_DEF;
  localparam int FRAC = FRAC_BITS_DEF;
  // The one command code that the block ignores.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1170;
  localparam int CYCLE_LIMIT = 5_000_000;
  localparam int DRAIN_LIMIT = 20_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_OFF_CYCLES = 400;

  typedef enum int {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PATTERN
  } rx_mode_e;

  // One span word as the block should report it.
  typedef struct packed {
    logic [XW-1:0] row;
    logic [LW-1:0] left;
    logic [XW-1:0] right;
    logic          valid;
  } span_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  // start_x, start_y, end_x, end_y, query_row, zero padding
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i = '0;
  // command
  logic [CMD_W-1:0]       s_axis_tuser_i = CMD_CLEAR;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  // span_row, span_left, span_right, zero padding
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  // span_valid
  logic [0:0]             m_axis_tuser_o;

  // Shadow copy of the edge tables and the spans still owed by the block.
  logic [LW-1:0] left_edge_tbl [NUM_ROWS];
  logic [XW-1:0] right_edge_tbl [NUM_ROWS];
  span_t         pending_spans [$];

  int       fail_count = 0;
  int       items_sent = 0;
  int       cycle_count = 0;
  int       hold_cycles = 0;
  int       rx_phase = 0;
  int       burst_left = 0;
  bit       tx_steady = 1'b1;
  rx_mode_e rx_mode = RX_ALWAYS;

  convex_polygon_span_fill_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Abandon the run if the block stops making progress.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_convex_polygon_span_fill_top failed");
      $finish;
    end
  end

  function automatic logic [XW-1:0] rnd9();
    return XW'($urandom_range(0, 511));
  endfunction

  function automatic void clear_edge_tables();
    for (int r = 0; r < NUM_ROWS; r++) begin
      left_edge_tbl[r] = EMPTY_LEFT;
      right_edge_tbl[r] = '0;
    end
  endfunction

  // Walk one edge from its lower endpoint upwards in fixed point and widen
  // every row it crosses. With equal y the end point is taken as the lower one.
  function automatic void trace_edge(logic [XW-1:0] sx, logic [XW-1:0] sy,
                                     logic [XW-1:0] ex, logic [XW-1:0] ey);
    logic [XW-1:0] lo_x, lo_y, hi_x, hi_y, dx, xi;
    logic [63:0]   step, xpos;
    bit            leftward;
    int            dy;
    if (sy < ey) begin
      lo_x = sx; lo_y = sy; hi_x = ex; hi_y = ey;
    end else begin
      lo_x = ex; lo_y = ey; hi_x = sx; hi_y = sy;
    end
    dy = int'(hi_y) - int'(lo_y);
    leftward = hi_x < lo_x;
    dx = leftward ? lo_x - hi_x : hi_x - lo_x;
    step = (dy != 0) ? (64'(dx) << FRAC) / 64'(dy) : 64'd0;
    xpos = 64'(lo_x) << FRAC;
    for (int y = int'(lo_y); y <= int'(hi_y); y++) begin
      if (y < NUM_ROWS) begin
        xi = XW'(xpos >> FRAC);
        if ({1'b0, xi} < left_edge_tbl[y]) begin
          left_edge_tbl[y] = {1'b0, xi};
        end
        if (xi > right_edge_tbl[y]) begin
          right_edge_tbl[y] = xi;
        end
      end
      if (leftward) begin
        xpos = (xpos >= step) ? xpos - step : 64'd0;
      end else begin
        xpos = xpos + step;
      end
    end
  endfunction

  function automatic span_t lookup_span(logic [XW-1:0] row);
    span_t s;
    s.row = row;
    s.left = EMPTY_LEFT;
    s.right = '0;
    if (row < NUM_ROWS) begin
      s.left = left_edge_tbl[row];
      s.right = right_edge_tbl[row];
    end
    s.valid = (s.left <= {1'b0, s.right});
    return s;
  endfunction

  // Offer one command word, wait for it to be taken and update the shadow
  // tables. Valid stays high afterwards while the current burst lasts.
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [XW-1:0] sx,
                           input logic [XW-1:0] sy, input logic [XW-1:0] ex,
                           input logic [XW-1:0] ey, input logic [XW-1:0] qr);
    if (!tx_steady && burst_left == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {{IN_PAD_W{1'b0}}, qr, ey, ex, sy, sx};
    s_axis_tuser_i <= cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (burst_left > 0) begin
      burst_left--;
    end
    case (cmd)
      CMD_CLEAR: clear_edge_tables();
      CMD_EDGE: trace_edge(sx, sy, ex, ey);
      CMD_READ: pending_spans.push_back(lookup_span(qr));
      default: ;
    endcase
    if (cmd != CMD_UNUSED) begin
      items_sent++;
    end
  endtask

  // Edge with its endpoints given in either order at random.
  task automatic send_edge(input logic [XW-1:0] x1, input logic [XW-1:0] y1,
                           input logic [XW-1:0] x2, input logic [XW-1:0] y2);
    if ($urandom_range(0, 1) == 0) begin
      send_word(CMD_EDGE, x1, y1, x2, y2, rnd9());
    end else begin
      send_word(CMD_EDGE, x2, y2, x1, y1, rnd9());
    end
  endtask

  task automatic send_read(input logic [XW-1:0] row);
    send_word(CMD_READ, rnd9(), rnd9(), rnd9(), rnd9(), row);
  endtask

  // Stop offering words and wait until every owed span has come back.
  task automatic drain_spans();
    int waited = 0;
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    while (pending_spans.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_spans.size() != 0) begin
      $error("%0d span words never arrived", pending_spans.size());
      fail_count++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Receiver: a long hold-off when asked, otherwise the current stall style.
  initial begin
    forever begin
      @(posedge clk_i);
      rx_phase++;
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready_i <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS: m_axis_tready_i <= 1'b1;
          RX_RANDOM: m_axis_tready_i <= ($urandom_range(0, 99) < 60);
          default: m_axis_tready_i <= ((rx_phase % 7) < 4);
        endcase
      end
    end
  end

  // Compare each span word taken from the block with the oldest expectation.
  always @(posedge clk_i) begin
    span_t         want;
    logic [XW-1:0] got_row, got_right;
    logic [LW-1:0] got_left;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_row = m_axis_tdata_o[XW-1:0];
      got_left = m_axis_tdata_o[XW +: LW];
      got_right = m_axis_tdata_o[XW+LW +: XW];
      if (pending_spans.size() == 0) begin
        $error("unexpected span word for row %0d", got_row);
        fail_count++;
      end else begin
        want = pending_spans.pop_front();
        if (got_row !== want.row) begin
          $error("span_row: expected %0d, got %0d", want.row, got_row);
          fail_count++;
        end
        if (got_left !== want.left) begin
          $error("span_left: expected %0d, got %0d", want.left, got_left);
          fail_count++;
        end
        if (got_right !== want.right) begin
          $error("span_right: expected %0d, got %0d", want.right, got_right);
          fail_count++;
        end
        if (m_axis_tuser_o[0] !== want.valid) begin
          $error("span_valid: expected %0d, got %0d", want.valid, m_axis_tuser_o[0]);
          fail_count++;
        end
      end
    end
  end

  // Rows straight after reset are empty.
  task automatic test_reset_contents();
    send_read(9'd0);
    send_read(9'd1);
    send_read(9'd255);
    send_read(9'd511);
  endtask

  // Edges spanning the whole table, leaning right and leaning left.
  task automatic test_full_height_edges();
    send_word(CMD_EDGE, 9'd0, 9'd0, 9'd511, 9'd511, 9'd0);
    send_word(CMD_EDGE, 9'd0, 9'd511, 9'd511, 9'd0, 9'd511);
    send_read(9'd0);
    send_read(9'd256);
    send_read(9'd511);
  endtask

  // A horizontal edge only marks its lower endpoint, which is the end point.
  task automatic test_horizontal_edge();
    send_word(CMD_CLEAR, 9'd511, 9'd511, 9'd511, 9'd511, 9'd511);
    send_word(CMD_EDGE, 9'd100, 9'd300, 9'd400, 9'd300, 9'd0);
    send_word(CMD_EDGE, 9'd20, 9'd300, 9'd30, 9'd300, 9'd0);
    send_read(9'd300);
    send_read(9'd301);
  endtask

  // A vertical edge has no slope and fills a single column.
  task automatic test_vertical_edge();
    send_word(CMD_EDGE, 9'd50, 9'd10, 9'd50, 9'd20, 9'd0);
    send_read(9'd10);
    send_read(9'd20);
    send_read(9'd21);
  endtask

  // The unused command code must leave the tables alone.
  task automatic test_unused_command();
    send_word(CMD_UNUSED, 9'd511, 9'd511, 9'd511, 9'd511, 9'd511);
    send_word(CMD_UNUSED, 9'd0, 9'd0, 9'd511, 9'd511, 9'd0);
    send_read(9'd300);
    send_read(9'd15);
  endtask

  task automatic test_clear();
    send_word(CMD_CLEAR, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0);
    send_read(9'd300);
    send_read(9'd15);
  endtask

  // Receiver holds off while reads keep coming, so the input must stall.
  task automatic test_backpressure();
    tx_steady = 1'b1;
    hold_cycles = HOLD_OFF_CYCLES;
    send_word(CMD_EDGE, 9'd10, 9'd5, 9'd200, 9'd60, 9'd0);
    for (int i = 0; i < 12; i++) begin
      send_read(XW'($urandom_range(0, 70)));
    end
    rx_mode = RX_RANDOM;
    for (int i = 0; i < 6; i++) begin
      send_read(XW'($urandom_range(0, 70)));
    end
  endtask

  // A convex shape drawn into clean tables, then rows in and around it read.
  task automatic draw_random_polygon();
    int            h, y0, r;
    logic [XW-1:0] ax, bx, cx, cy, top;
    h = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 511) : $urandom_range(1, 40);
    y0 = $urandom_range(0, 511 - h);
    top = XW'(y0 + h);
    ax = rnd9();
    bx = rnd9();
    cx = rnd9();
    cy = XW'($urandom_range(y0, y0 + h));
    send_word(CMD_CLEAR, rnd9(), rnd9(), rnd9(), rnd9(), rnd9());
    if ($urandom_range(0, 3) == 0) begin
      // Box: two vertical sides and two horizontal ones.
      send_edge(ax, XW'(y0), ax, top);
      send_edge(bx, XW'(y0), bx, top);
      send_edge(ax, XW'(y0), bx, XW'(y0));
      send_edge(ax, top, bx, top);
    end else begin
      // Triangle with one vertex on each limit row and one in between.
      send_edge(ax, XW'(y0), bx, top);
      send_edge(bx, top, cx, cy);
      send_edge(cx, cy, ax, XW'(y0));
    end
    repeat ($urandom_range(2, 8)) begin
      if ($urandom_range(0, 7) == 0) begin
        r = $urandom_range(0, 511);
      end else begin
        r = int'($urandom_range(0, h + 4)) + y0 - 2;
      end
      if (r < 0) r = 0;
      if (r > 511) r = 511;
      send_read(XW'(r));
    end
  endtask

  // Loose command words with no polygon structure behind them.
  task automatic send_noise();
    int            pick;
    logic [XW-1:0] sy;
    pick = $urandom_range(0, 9);
    sy = rnd9();
    if (pick == 0) begin
      send_word(CMD_CLEAR, rnd9(), rnd9(), rnd9(), rnd9(), rnd9());
    end else if (pick == 1) begin
      send_word(CMD_UNUSED, rnd9(), rnd9(), rnd9(), rnd9(), rnd9());
    end else if (pick < 6) begin
      send_word(CMD_EDGE, rnd9(), sy, rnd9(), XW'(sy + $urandom_range(0, 30)), rnd9());
    end else begin
      send_read(rnd9());
    end
  endtask

  task automatic test_random_polygons();
    int target;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      rx_mode = rx_mode_e'($urandom_range(0, 2));
      tx_steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) != 0) begin
        draw_random_polygon();
      end else begin
        repeat ($urandom_range(1, 4)) send_noise();
      end
    end
  endtask

  initial begin
    clear_edge_tables();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_contents();
    rx_mode = RX_PATTERN;
    test_full_height_edges();
    tx_steady = 1'b0;
    rx_mode = RX_RANDOM;
    test_horizontal_edge();
    test_vertical_edge();
    test_unused_command();
    test_clear();
    test_backpressure();
    test_random_polygons();
    rx_mode = RX_ALWAYS;
    drain_spans();
    if (fail_count == 0) begin
      $display("tb_convex_polygon_span_fill_top passed");
    end else begin
      $display("tb_convex_polygon_span_fill_top failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/cpsf_pkg.sv
rtl/core/cpsf_ram.sv
rtl/core/cpsf_div.sv
rtl/core/convex_polygon_span_fill_top.sv
bench/tb_convex_polygon_span_fill_top.sv
